[rtl/rgmn_pkg.sv]
// rgmn_pkg: widths and constants shared by the relevance grid max normalizer
// used by the channel interfaces and the top level; no dependencies
package rgmn_pkg;

  localparam int SampleW     = 16;  // signed q8.8 sample
  localparam int ValW        = 15;  // clamped unsigned q7.8 value, peak, average
  localparam int LevelW      = 16;  // unsigned q1.15 level
  localparam int RowW        = 3;   // cell row and column
  localparam int SideW       = 4;   // grid_side register
  localparam int DvdW        = 2 * ValW;  // divider dividend: value shifted by 15
  localparam int MaxGridSide = 8;

  localparam logic [SideW-1:0]  SideReset = 4'd8;
  localparam logic [LevelW-1:0] LevelOne  = 16'h8000;

endpackage

[rtl/rgmn_if.sv]
// rgmn_if: valid/ready channels for samples in and normalized cells out
// depends on rgmn_pkg for field widths
interface rgmn_sample_if;
  import rgmn_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  logic                      frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface rgmn_cell_if;
  import rgmn_pkg::*;

  logic              valid;
  logic              ready;
  logic [RowW-1:0]   cell_row;
  logic [RowW-1:0]   cell_col;
  logic [LevelW-1:0] level;
  logic [ValW-1:0]   peak;
  logic [ValW-1:0]   average;
  logic              last_cell;

  modport source (output valid, output cell_row, output cell_col, output level,
                  output peak, output average, output last_cell, input ready);
  modport sink   (input valid, input cell_row, input cell_col, input level,
                  input peak, input average, input last_cell, output ready);
endinterface

[rtl/relevance_grid_max_normalizer_top.sv]
// relevance_grid_max_normalizer_top: collects a frame of relevance samples and
// emits each grid cell divided by the frame peak; uses rgmn_pkg and rgmn_if
//
// Samples are taken one per cycle while a frame is being collected; negative
// samples count as zero and samples beyond the effective side squared are
// dropped. The transfer that carries frame_end starts the output walk, during
// which no sample is taken. All divisions share one restoring divider that
// retires one quotient bit per cycle: the frame mean is a divider load and
// then the divide steps, and each cell is a store read, a divider load, the
// divide steps and an output state that holds the cell until ready takes it.
// After the transfer of a frame's last cell the next frame may start at once.
module relevance_grid_max_normalizer_top #(
  parameter int MAX_GRID_SIDE = rgmn_pkg::MaxGridSide
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      grid_side_we,
  input  logic [rgmn_pkg::SideW-1:0] grid_side_wdata,
  rgmn_sample_if.sink               samples,
  rgmn_cell_if.source               cells
);
  import rgmn_pkg::*;

  localparam int Depth = MAX_GRID_SIDE * MAX_GRID_SIDE;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int SumW  = ValW + $clog2(Depth);
  localparam int StepW = $clog2(DvdW);

  typedef enum logic [6:0] {
    ST_COLLECT   = 7'b0000001,
    ST_MEAN_LOAD = 7'b0000010,
    ST_MEAN_DIV  = 7'b0000100,
    ST_READ      = 7'b0001000,
    ST_CELL_LOAD = 7'b0010000,
    ST_CELL_DIV  = 7'b0100000,
    ST_EMIT      = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [SideW-1:0] grid_side;
  logic [CntW-1:0]  count;
  logic [ValW-1:0]  peak;
  logic [SumW-1:0]  sum;
  logic [ValW-1:0]  avg;
  logic [CntW-1:0]  idx;
  logic [RowW-1:0]  row;
  logic [RowW-1:0]  col;
  logic             rd_hit;

  logic [ValW-1:0]  store [Depth];
  logic [ValW-1:0]  rd_data;

  // shared divider
  logic [DvdW-1:0]  dvd;
  logic [ValW-1:0]  rem;
  logic [ValW-1:0]  dsr;
  logic [StepW-1:0] step;
  logic [ValW:0]    rem_sh;
  logic [ValW:0]    rem_diff;
  logic             rem_ge;
  logic [ValW-1:0]  rem_next;
  logic [DvdW-1:0]  dvd_next;
  logic             div_done;

  logic [LevelW-1:0] level_next;
  logic [LevelW-1:0] level;
  logic [RowW-1:0]   out_row;
  logic [RowW-1:0]   out_col;
  logic              out_last;

  logic [SideW-1:0]   side;
  logic [2*SideW-1:0] side_sq;
  logic [CntW-1:0]    num_cells;
  logic [ValW-1:0]    clamped;
  logic               take;
  logic               room;
  logic               idx_last;
  logic               col_last;
  logic               cell_done;

  // effective side: zero reads as one, larger values saturate
  always_comb begin
    if (grid_side == '0) begin
      side = SideW'(1);
    end else if (grid_side > SideW'(MAX_GRID_SIDE)) begin
      side = SideW'(MAX_GRID_SIDE);
    end else begin
      side = grid_side;
    end
  end

  assign side_sq   = {{SideW{1'b0}}, side} * {{SideW{1'b0}}, side};
  assign num_cells = side_sq[CntW-1:0];

  assign clamped  = samples.sample[SampleW-1] ? '0 : samples.sample[ValW-1:0];
  assign take     = samples.valid && samples.ready;
  assign room     = count < num_cells;
  assign idx_last = idx == (num_cells - CntW'(1));
  assign col_last = SideW'(col) == (side - SideW'(1));
  assign cell_done = cells.valid && cells.ready;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh   = {rem, dvd[DvdW-1]};
  assign rem_diff = rem_sh - {1'b0, dsr};
  assign rem_ge   = rem_sh >= {1'b0, dsr};
  assign rem_next = rem_ge ? rem_diff[ValW-1:0] : rem_sh[ValW-1:0];
  assign dvd_next = {dvd[DvdW-2:0], rem_ge};
  assign div_done = step == StepW'(DvdW - 1);

  always_comb begin
    if (peak == '0) begin
      level_next = '0;
    end else if (dvd_next > DvdW'(LevelOne)) begin
      level_next = LevelOne;
    end else begin
      level_next = dvd_next[LevelW-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (take && samples.frame_end) state_next = ST_MEAN_LOAD;
      end
      ST_MEAN_LOAD: state_next = ST_MEAN_DIV;
      ST_MEAN_DIV: begin
        if (div_done) state_next = ST_READ;
      end
      ST_READ:      state_next = ST_CELL_LOAD;
      ST_CELL_LOAD: state_next = ST_CELL_DIV;
      ST_CELL_DIV: begin
        if (div_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (cell_done) state_next = out_last ? ST_COLLECT : ST_READ;
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COLLECT;
      grid_side <= SideReset;
      count     <= '0;
      peak      <= '0;
      sum       <= '0;
      idx       <= '0;
      row       <= '0;
      col       <= '0;
      rd_hit    <= 1'b0;
    end else begin
      state <= state_next;
      if (grid_side_we) grid_side <= grid_side_wdata;
      if (take && room) begin
        count <= count + CntW'(1);
        sum   <= sum + SumW'(clamped);
        if (clamped > peak) peak <= clamped;
      end
      if (state == ST_READ) rd_hit <= idx < count;
      if (cell_done) begin
        if (out_last) begin
          // frame finished: clear for the next one
          count <= '0;
          peak  <= '0;
          sum   <= '0;
          idx   <= '0;
          row   <= '0;
          col   <= '0;
        end else begin
          idx <= idx + CntW'(1);
          if (col_last) begin
            col <= '0;
            row <= row + RowW'(1);
          end else begin
            col <= col + RowW'(1);
          end
        end
      end
    end
  end

  // cell store, written in raster order; entries at or past count read as zero
  always_ff @(posedge clk) begin
    if (take && room) store[count[AddrW-1:0]] <= clamped;
    if (state == ST_READ) rd_data <= store[idx[AddrW-1:0]];
  end

  always_ff @(posedge clk) begin
    unique case (state) inside
      ST_MEAN_LOAD: begin
        dvd  <= DvdW'(sum);
        dsr  <= ValW'(count);
        rem  <= '0;
        step <= '0;
      end
      ST_CELL_LOAD: begin
        dvd  <= rd_hit ? {rd_data, {ValW{1'b0}}} : '0;
        dsr  <= peak;
        rem  <= '0;
        step <= '0;
      end
      ST_MEAN_DIV, ST_CELL_DIV: begin
        dvd  <= dvd_next;
        rem  <= rem_next;
        step <= step + StepW'(1);
      end
      default: begin
      end
    endcase
    if (state == ST_MEAN_DIV && div_done) begin
      avg <= (count == '0) ? '0 : dvd_next[ValW-1:0];
    end
    if (state == ST_CELL_DIV && div_done) begin
      level    <= level_next;
      out_row  <= row;
      out_col  <= col;
      out_last <= idx_last;
    end
  end

  assign samples.ready   = state == ST_COLLECT;
  assign cells.valid     = state == ST_EMIT;
  assign cells.cell_row  = out_row;
  assign cells.cell_col  = out_col;
  assign cells.level     = level;
  assign cells.peak      = peak;
  assign cells.average   = avg;
  assign cells.last_cell = out_last;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(samples.ready && cells.valid))
    else $error("sample port open while a cell is offered");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("accepted count beyond store depth");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (cell_done && cells.last_cell) |=> (count == '0 && peak == '0 && samples.ready))
    else $error("frame state not cleared after last cell");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    cells.valid |-> (cells.level <= LevelOne && (cells.peak != '0 || cells.level == '0)))
    else $error("level out of range for peak");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_MEAN_DIV || state == ST_CELL_DIV) && dsr != '0) |-> rem < dsr)
    else $error("divider remainder not below divisor");
`endif

endmodule

[tb/tb.sv]
// tb: self-checking bench for relevance_grid_max_normalizer_top, built on rgmn_pkg and rgmn_if
// drives frames of q8.8 samples with random gaps and output stalls, predicts every emitted
// cell from a software mirror of the grid store and checks each field of each transfer
module tb;
  import rgmn_pkg::*;

  localparam int IdleLimit   = 4000;
  localparam int ConfigPause = 8;
  localparam int DrainCycles = 40;
  localparam int RandomItems = 230;
  localparam int MaxReports  = 50;

  typedef struct {
    logic [RowW-1:0]   row;
    logic [RowW-1:0]   col;
    logic [LevelW-1:0] level;
    logic [ValW-1:0]   peak;
    logic [ValW-1:0]   average;
    logic              last_cell;
  } cell_result_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             grid_side_we;
  logic [SideW-1:0] grid_side_wdata;

  rgmn_sample_if samples_ch ();
  rgmn_cell_if   cells_ch ();

  relevance_grid_max_normalizer_top dut (
    .clk             (clk),
    .rst             (rst),
    .grid_side_we    (grid_side_we),
    .grid_side_wdata (grid_side_wdata),
    .samples         (samples_ch),
    .cells           (cells_ch)
  );

  // mirror of the block's frame state
  logic [ValW-1:0]  grid_mirror [64];
  int               mirror_count;
  int               mirror_peak;
  int               mirror_sum;
  logic [SideW-1:0] mirror_side;

  cell_result_t cells_due[$];
  int           error_count = 0;
  int           idle_cycles = 0;
  int           stall_left  = 0;
  bit           quiet       = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int eff_side(input logic [SideW-1:0] side);
    if (side == 0) return 1;
    if (side > MaxGridSide) return MaxGridSide;
    return side;
  endfunction

  function automatic void clear_mirror();
    foreach (grid_mirror[i]) grid_mirror[i] = '0;
    mirror_count = 0;
    mirror_peak  = 0;
    mirror_sum   = 0;
  endfunction

  // accumulate one sample; on frame end queue one normalized cell per grid position
  function automatic void take_sample(input logic [SampleW-1:0] raw, input logic last);
    int           side;
    int           n_cells;
    int           v;
    int           avg;
    longint       lvl;
    cell_result_t c;
    side    = eff_side(mirror_side);
    n_cells = side * side;
    v       = raw[SampleW-1] ? 0 : int'(raw[ValW-1:0]);
    if (mirror_count < n_cells) begin
      grid_mirror[mirror_count] = v[ValW-1:0];
      mirror_count++;
      if (v > mirror_peak) mirror_peak = v;
      mirror_sum += v;
    end
    if (!last) return;
    avg = (mirror_count != 0) ? mirror_sum / mirror_count : 0;
    for (int i = 0; i < n_cells; i++) begin
      lvl = 0;
      if (mirror_peak != 0) begin
        lvl = (longint'(grid_mirror[i]) << 15) / mirror_peak;
        if (lvl > longint'(LevelOne)) lvl = longint'(LevelOne);
      end
      c.row       = RowW'(i / side);
      c.col       = RowW'(i % side);
      c.level     = LevelW'(lvl);
      c.peak      = ValW'(mirror_peak);
      c.average   = ValW'(avg);
      c.last_cell = (i + 1 == n_cells);
      cells_due.push_back(c);
    end
    clear_mirror();
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      if (error_count < MaxReports)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // sample-side transfers and register writes feed the mirror
  always @(posedge clk) begin
    if (rst) begin
      mirror_side = SideReset;
      clear_mirror();
    end else begin
      if (grid_side_we) mirror_side = grid_side_wdata;
      if (samples_ch.valid && samples_ch.ready)
        take_sample(samples_ch.sample, samples_ch.frame_end);
    end
  end

  // cell-side transfers are compared in order; ready stalls at random
  always @(posedge clk) begin : cell_check
    cell_result_t want;
    if (!rst && cells_ch.valid && cells_ch.ready) begin
      if (cells_due.size() == 0) begin
        if (error_count < MaxReports)
          $display("%0t: unexpected cell, expected none actual row %0d col %0d level %0d",
                   $time, cells_ch.cell_row, cells_ch.cell_col, cells_ch.level);
        error_count++;
      end else begin
        want = cells_due.pop_front();
        check_field("cell_row", want.row, cells_ch.cell_row);
        check_field("cell_col", want.col, cells_ch.cell_col);
        check_field("level", want.level, cells_ch.level);
        check_field("peak", want.peak, cells_ch.peak);
        check_field("average", want.average, cells_ch.average);
        check_field("last_cell", want.last_cell, cells_ch.last_cell);
      end
    end
    if (stall_left > 0) begin
      stall_left     <= stall_left - 1;
      cells_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left     <= pick_gap();
      cells_ch.ready <= 1'b0;
    end else begin
      cells_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (samples_ch.valid && samples_ch.ready) || (cells_ch.valid && cells_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic [SampleW-1:0] value, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      samples_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_ch.valid     <= 1'b1;
    samples_ch.sample    <= value;
    samples_ch.frame_end <= last;
    @(posedge clk);
    while (!samples_ch.ready) @(posedge clk);
  endtask

  // let every pending cell drain, then give the block time to settle
  task automatic wait_idle(input int settle);
    samples_ch.valid <= 1'b0;
    @(posedge clk);
    while (cells_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_side(input logic [SideW-1:0] value);
    wait_idle(ConfigPause);
    grid_side_we    <= 1'b1;
    grid_side_wdata <= value;
    @(posedge clk);
    grid_side_we <= 1'b0;
  endtask

  function automatic logic [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
      2:       return '0;
      3, 4:    return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    write_side(4'd2);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0001, 1'b1);
    // all negative: peak stays zero so every level is zero
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h8000, 1'b1);
  endtask

  task automatic test_side_clamp();
    write_side(4'd0);
    send_sample(16'h0100, 1'b1);
    send_sample(16'h0000, 1'b1);
    // short frames on the largest grid leave most cells empty
    write_side(4'd15);
    send_sample(16'h1234, 1'b0);
    send_sample(16'h4321, 1'b1);
    write_side(4'd9);
    send_sample(16'h0001, 1'b1);
  endtask

  task automatic test_store_full();
    write_side(4'd1);
    send_sample(16'h0200, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0300, 1'b1);
  endtask

  task automatic test_side_change();
    write_side(4'd3);
    for (int i = 0; i < 5; i++) send_sample(16'(16'h0040 * (i + 1)), 1'b0);
    // shrink below the cells already taken: the end sample is dropped
    write_side(4'd2);
    send_sample(16'h0700, 1'b1);
    send_sample(16'h0123, 1'b0);
    send_sample(16'h0321, 1'b0);
    write_side(4'd3);
    send_sample(16'h0222, 1'b1);
  endtask

  task automatic test_random_frames();
    int sent;
    int r;
    int n_cells;
    int len;
    logic [SideW-1:0] side;
    sent = 0;
    while (sent < RandomItems) begin
      if ($urandom_range(0, 2) == 0 || sent == 0) begin
        r = $urandom_range(0, 9);
        if (r < 6)       side = SideW'($urandom_range(1, 4));
        else if (r < 8)  side = SideW'($urandom_range(5, 7));
        else if (r == 8) side = SideW'(MaxGridSide);
        else             side = ($urandom_range(0, 7) == 0) ? '0 : SideW'($urandom_range(9, 15));
        write_side(side);
      end
      // the last written value, free of any race with the mirror update
      n_cells = eff_side(grid_side_wdata) ** 2;
      r = $urandom_range(0, 9);
      if (r < 7)      len = n_cells;
      else if (r < 9) len = $urandom_range(1, n_cells);
      else            len = n_cells + $urandom_range(1, 4);
      quiet = ($urandom_range(0, 5) == 0);
      for (int k = 0; k < len; k++) send_sample(rand_sample(), k == len - 1);
      quiet = 1'b0;
      sent += len;
    end
  endtask

  initial begin
    rst                  = 1'b1;
    grid_side_we         = 1'b0;
    grid_side_wdata      = '0;
    samples_ch.valid     = 1'b0;
    samples_ch.sample    = '0;
    samples_ch.frame_end = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_extremes();
    test_side_clamp();
    test_store_full();
    test_side_change();
    test_random_frames();

    wait_idle(DrainCycles);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
